// ===== src/mfud_pkg.sv =====
// ----------------------------------------------------------------------------
// mfud_pkg
// Shared widths, register codes, reset values and types of the motor
// feedback unwrap decoder.
// ----------------------------------------------------------------------------
package mfud_pkg;

    localparam int NumChannels = 2;

    localparam int ChanW     = 1;
    localparam int IdW       = 11;
    localparam int AngleW    = 16;
    localparam int RawW      = 16;
    localparam int TempW     = 8;
    localparam int TurnW     = 24;
    localparam int TotalW    = 37;
    localparam int PosW      = 48;
    localparam int FixW      = 32;
    localparam int GainW     = 32;
    localparam int FrameCntW = 16;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 32;

    localparam int RevShift  = 13;            // 8192 counts per revolution
    localparam int QShift    = 8;             // Q8.24 * raw -> Q16.16
    localparam int GainHalfW = GainW / 2;
    localparam int PosPartW  = TotalW + GainHalfW + 1;
    localparam int PosFullW  = PosPartW + GainHalfW;
    localparam int RawProdW  = RawW + GainW + 1;

    localparam logic signed [AngleW:0] JumpLimit = (AngleW + 1)'(4096);

    localparam logic [CfgIdxW-1:0] RegMotorId      = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegMotorChannel = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] RegWarmupFrames = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] RegPositionGain = CfgIdxW'(3);
    localparam logic [CfgIdxW-1:0] RegVelocityGain = CfgIdxW'(4);
    localparam logic [CfgIdxW-1:0] RegTorqueGain   = CfgIdxW'(5);

    localparam logic [IdW-1:0]       MotorIdRst      = IdW'(513);
    localparam logic [ChanW-1:0]     MotorChannelRst = ChanW'(0);
    localparam logic [FrameCntW-1:0] WarmupFramesRst = FrameCntW'(50);
    localparam logic [GainW-1:0]     PositionGainRst = GainW'(12868);
    localparam logic [GainW-1:0]     VelocityGainRst = GainW'(1756918);
    localparam logic [GainW-1:0]     TorqueGainRst   = GainW'(0);

    typedef struct packed {
        logic [IdW-1:0]       motor_id;
        logic [ChanW-1:0]     motor_channel;
        logic [FrameCntW-1:0] warmup_frames;
        logic [GainW-1:0]     position_gain;
        logic [GainW-1:0]     velocity_gain;
        logic [GainW-1:0]     torque_gain;
    } cfg_t;

    typedef struct packed {
        logic [ChanW-1:0]         bus_channel;
        logic [IdW-1:0]           frame_id;
        logic [AngleW-1:0]        angle_raw;
        logic signed [RawW-1:0]   speed_raw;
        logic signed [RawW-1:0]   current_raw;
        logic [TempW-1:0]         temperature_raw;
    } frame_t;

    typedef struct packed {
        logic signed [TotalW-1:0] total_count;
        logic signed [TurnW-1:0]  turn_count;
        logic signed [RawW-1:0]   speed_raw;
        logic signed [RawW-1:0]   current_raw;
        logic [TempW-1:0]         temperature;
        logic                     in_warmup;
    } unw_t;

    typedef struct packed {
        logic signed [TotalW-1:0] total_count;
        logic signed [TurnW-1:0]  turn_count;
        logic signed [PosW-1:0]   position_q16;
        logic signed [FixW-1:0]   velocity_q16;
        logic signed [FixW-1:0]   torque_q16;
        logic [TempW-1:0]         temperature;
        logic                     in_warmup;
    } result_t;

endpackage

// ===== src/mfud_ifs.sv =====
// ----------------------------------------------------------------------------
// mfud channel interfaces
// Valid/ready channels for feedback frames, decoded results and register
// writes.
// ----------------------------------------------------------------------------
interface mfud_frame_if
    import mfud_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [ChanW-1:0]       bus_channel;
    logic [IdW-1:0]         frame_id;
    logic [AngleW-1:0]      angle_raw;
    logic signed [RawW-1:0] speed_raw;
    logic signed [RawW-1:0] current_raw;
    logic [TempW-1:0]       temperature_raw;

    modport source (output valid, bus_channel, frame_id, angle_raw, speed_raw,
                    current_raw, temperature_raw, input ready);
    modport sink   (input valid, bus_channel, frame_id, angle_raw, speed_raw,
                    current_raw, temperature_raw, output ready);
endinterface

interface mfud_result_if
    import mfud_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [TotalW-1:0] total_count;
    logic signed [TurnW-1:0]  turn_count;
    logic signed [PosW-1:0]   position_q16;
    logic signed [FixW-1:0]   velocity_q16;
    logic signed [FixW-1:0]   torque_q16;
    logic [TempW-1:0]         temperature;
    logic                     in_warmup;

    modport source (output valid, total_count, turn_count, position_q16,
                    velocity_q16, torque_q16, temperature, in_warmup, input ready);
    modport sink   (input valid, total_count, turn_count, position_q16,
                    velocity_q16, torque_q16, temperature, in_warmup, output ready);
endinterface

interface mfud_cfg_if
    import mfud_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/mfud_cfg.sv =====
// ----------------------------------------------------------------------------
// mfud_cfg
// Configuration register file, one write transaction per cycle.
// ----------------------------------------------------------------------------
module mfud_cfg
    import mfud_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  logic [CfgIdxW-1:0]  wr_index,
    input  logic [CfgDataW-1:0] wr_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign wr_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            case (wr_index)
                RegMotorId:      cfg_next.motor_id      = wr_data[IdW-1:0];
                RegMotorChannel: cfg_next.motor_channel = wr_data[ChanW-1:0];
                RegWarmupFrames: cfg_next.warmup_frames = wr_data[FrameCntW-1:0];
                RegPositionGain: cfg_next.position_gain = wr_data[GainW-1:0];
                RegVelocityGain: cfg_next.velocity_gain = wr_data[GainW-1:0];
                RegTorqueGain:   cfg_next.torque_gain   = wr_data[GainW-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_id      <= MotorIdRst;
            cfg_reg.motor_channel <= MotorChannelRst;
            cfg_reg.warmup_frames <= WarmupFramesRst;
            cfg_reg.position_gain <= PositionGainRst;
            cfg_reg.velocity_gain <= VelocityGainRst;
            cfg_reg.torque_gain   <= TorqueGainRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/mfud_unwrap.sv =====
// ----------------------------------------------------------------------------
// mfud_unwrap
// Input register, motor filter, warmup and multi-turn tracking state.
// ----------------------------------------------------------------------------
module mfud_unwrap
    import mfud_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  frame_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output unw_t   out_data
);

    logic                 s0_valid_reg, s0_valid_next;
    frame_t               s0_reg;
    logic                 s1_valid_reg, s1_valid_next;
    unw_t                 s1_reg, s1_next;

    logic [FrameCntW-1:0] frames_seen_reg, frames_seen_next;
    logic [AngleW-1:0]    prev_angle_reg, prev_angle_next;
    logic [AngleW-1:0]    offset_reg, offset_next;
    logic [TurnW-1:0]     turns_reg, turns_next;

    logic                 s1_ready;
    logic                 s0_adv;
    logic                 match;
    logic                 update;
    logic                 warm;
    logic [FrameCntW-1:0] frames_inc;
    logic signed [AngleW:0] diff;
    logic [TurnW-1:0]     turns_base;
    logic [AngleW-1:0]    offset_use;

    assign s1_ready  = !s1_valid_reg || out_ready;
    assign s0_adv    = s0_valid_reg && s1_ready;
    assign in_ready  = !s0_valid_reg || s1_ready;
    assign out_valid = s1_valid_reg;
    assign out_data  = s1_reg;

    assign match = (32'(s0_reg.bus_channel) < NumChannels)
                && (s0_reg.bus_channel == cfg.motor_channel)
                && (s0_reg.frame_id == cfg.motor_id);
    assign update = s0_adv && match;

    always_comb
    begin
        frames_inc = (frames_seen_reg == {FrameCntW{1'b1}}) ? frames_seen_reg
                                                             : frames_seen_reg + 1'b1;
        diff       = $signed({1'b0, s0_reg.angle_raw}) - $signed({1'b0, prev_angle_reg});
        warm       = frames_inc < cfg.warmup_frames;
        offset_use = warm ? s0_reg.angle_raw : offset_reg;
        turns_base = warm ? '0 : turns_reg;
        if (diff >= JumpLimit)
            turns_next = turns_base - 1'b1;
        else if (diff <= -JumpLimit)
            turns_next = turns_base + 1'b1;
        else
            turns_next = turns_base;

        s1_next.total_count = $signed({turns_next, {RevShift{1'b0}}})
                            + $signed(TotalW'(s0_reg.angle_raw))
                            - $signed(TotalW'(offset_use));
        s1_next.turn_count  = turns_next;
        s1_next.speed_raw   = s0_reg.speed_raw;
        s1_next.current_raw = s0_reg.current_raw;
        s1_next.temperature = s0_reg.temperature_raw;
        s1_next.in_warmup   = warm;

        frames_seen_next = update ? frames_inc : frames_seen_reg;
        prev_angle_next  = update ? s0_reg.angle_raw : prev_angle_reg;
        offset_next      = update ? offset_use : offset_reg;

        s0_valid_next = in_ready ? in_valid : 1'b1;
        s1_valid_next = s1_ready ? update : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg    <= 1'b0;
            s1_valid_reg    <= 1'b0;
            frames_seen_reg <= '0;
            prev_angle_reg  <= '0;
            offset_reg      <= '0;
            turns_reg       <= '0;
        end
        else
        begin
            s0_valid_reg    <= s0_valid_next;
            s1_valid_reg    <= s1_valid_next;
            frames_seen_reg <= frames_seen_next;
            prev_angle_reg  <= prev_angle_next;
            offset_reg      <= offset_next;
            if (update)
                turns_reg <= turns_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s0_reg <= in_data;
        if (update)
            s1_reg <= s1_next;
    end

`ifndef NO_ASSERTIONS
    a_warm_turns: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.in_warmup |->
            (s1_reg.turn_count == 0 || s1_reg.turn_count == 1 || s1_reg.turn_count == -1))
        else $error("turn count outside +-1 on a warmup frame");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !update |=> $stable(prev_angle_reg) && $stable(turns_reg) && $stable(offset_reg))
        else $error("tracking state changed without a matched frame");

    a_frames_mono: assert property (@(posedge clk) disable iff (!rst_n)
        update |=> frames_seen_reg >= $past(frames_seen_reg) && frames_seen_reg != 0)
        else $error("frame count went backwards");
`endif

endmodule

// ===== src/mfud_scale.sv =====
// ----------------------------------------------------------------------------
// mfud_scale
// Gain multiply stage and Q16.16 shift/saturate stage feeding the result
// register.
// ----------------------------------------------------------------------------
module mfud_scale
    import mfud_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  unw_t    in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam int PosShW = PosFullW - QShift;
    localparam int RawShW = RawProdW - QShift;

    logic                       s2_valid_reg, s2_valid_next;
    logic                       s3_valid_reg, s3_valid_next;
    logic                       s2_ready, s3_ready;

    unw_t                       s2_reg;
    logic signed [PosPartW-1:0] pos_hi_reg, pos_hi_next;
    logic signed [PosPartW-1:0] pos_lo_reg, pos_lo_next;
    logic signed [RawProdW-1:0] vel_reg, vel_next;
    logic signed [RawProdW-1:0] tor_reg, tor_next;

    result_t                    s3_reg, s3_next;

    logic signed [PosFullW-1:0] pos_full;
    logic signed [PosShW-1:0]   pos_sh;
    logic signed [RawShW-1:0]   vel_sh;
    logic signed [RawShW-1:0]   tor_sh;

    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign in_ready  = s2_ready;
    assign out_valid = s3_valid_reg;
    assign out_data  = s3_reg;

    always_comb
    begin
        pos_hi_next = PosPartW'(in_data.total_count)
                    * PosPartW'($signed({1'b0, cfg.position_gain[GainW-1:GainHalfW]}));
        pos_lo_next = PosPartW'(in_data.total_count)
                    * PosPartW'($signed({1'b0, cfg.position_gain[GainHalfW-1:0]}));
        vel_next    = RawProdW'(in_data.speed_raw)
                    * RawProdW'($signed({1'b0, cfg.velocity_gain}));
        tor_next    = RawProdW'(in_data.current_raw)
                    * RawProdW'($signed({1'b0, cfg.torque_gain}));
        s2_valid_next = s2_ready ? in_valid : 1'b1;
    end

    // floor shift to Q16.16, then clamp to the field width
    always_comb
    begin
        pos_full = (PosFullW'(pos_hi_reg) <<< GainHalfW) + PosFullW'(pos_lo_reg);
        pos_sh   = pos_full[PosFullW-1:QShift];
        vel_sh   = vel_reg[RawProdW-1:QShift];
        tor_sh   = tor_reg[RawProdW-1:QShift];

        s3_next.total_count = s2_reg.total_count;
        s3_next.turn_count  = s2_reg.turn_count;
        s3_next.temperature = s2_reg.temperature;
        s3_next.in_warmup   = s2_reg.in_warmup;

        if (pos_sh[PosShW-1:PosW-1] == '0 || pos_sh[PosShW-1:PosW-1] == '1)
            s3_next.position_q16 = pos_sh[PosW-1:0];
        else
            s3_next.position_q16 = {pos_sh[PosShW-1], {(PosW-1){~pos_sh[PosShW-1]}}};

        if (vel_sh[RawShW-1:FixW-1] == '0 || vel_sh[RawShW-1:FixW-1] == '1)
            s3_next.velocity_q16 = vel_sh[FixW-1:0];
        else
            s3_next.velocity_q16 = {vel_sh[RawShW-1], {(FixW-1){~vel_sh[RawShW-1]}}};

        if (tor_sh[RawShW-1:FixW-1] == '0 || tor_sh[RawShW-1:FixW-1] == '1)
            s3_next.torque_q16 = tor_sh[FixW-1:0];
        else
            s3_next.torque_q16 = {tor_sh[RawShW-1], {(FixW-1){~tor_sh[RawShW-1]}}};

        s3_valid_next = s3_ready ? s2_valid_reg : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s2_ready)
        begin
            s2_reg     <= in_data;
            pos_hi_reg <= pos_hi_next;
            pos_lo_reg <= pos_lo_next;
            vel_reg    <= vel_next;
            tor_reg    <= tor_next;
        end
        if (s2_valid_reg && s3_ready)
            s3_reg <= s3_next;
    end

endmodule

// ===== src/motor_feedback_unwrap_decoder_unit.sv =====
// Throughput: one frame per cycle; the four-register pipeline (input, unwrap,
// gain products, result) advances every stage whose successor is free.
// Frames for another motor are dropped after the input register and give no result.
// Reset: configuration to defaults, frame count, angle, offset and turns to zero,
// pipeline empty.
// ----------------------------------------------------------------------------
// motor_feedback_unwrap_decoder_unit
// Multi-turn rotor feedback decoder with Q16.16 position, velocity and torque.
// ----------------------------------------------------------------------------
module motor_feedback_unwrap_decoder_unit
    import mfud_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    mfud_cfg_if.sink             cfg_wr,
    mfud_frame_if.sink           frame_in,
    mfud_result_if.source        result_out
);

    cfg_t    cfg;
    frame_t  frame;
    logic    unw_valid;
    logic    unw_ready;
    unw_t    unw;
    result_t result;

    assign frame.bus_channel     = frame_in.bus_channel;
    assign frame.frame_id        = frame_in.frame_id;
    assign frame.angle_raw       = frame_in.angle_raw;
    assign frame.speed_raw       = frame_in.speed_raw;
    assign frame.current_raw     = frame_in.current_raw;
    assign frame.temperature_raw = frame_in.temperature_raw;

    mfud_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg_wr.valid),
        .wr_ready (cfg_wr.ready),
        .wr_index (cfg_wr.index),
        .wr_data  (cfg_wr.data),
        .cfg      (cfg)
    );

    mfud_unwrap u_unwrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (frame_in.valid),
        .in_ready  (frame_in.ready),
        .in_data   (frame),
        .out_valid (unw_valid),
        .out_ready (unw_ready),
        .out_data  (unw)
    );

    mfud_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (unw_valid),
        .in_ready  (unw_ready),
        .in_data   (unw),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .out_data  (result)
    );

    assign result_out.total_count  = result.total_count;
    assign result_out.turn_count   = result.turn_count;
    assign result_out.position_q16 = result.position_q16;
    assign result_out.velocity_q16 = result.velocity_q16;
    assign result_out.torque_q16   = result.torque_q16;
    assign result_out.temperature  = result.temperature;
    assign result_out.in_warmup    = result.in_warmup;

endmodule

// ===== bench/motor_feedback_unwrap_decoder_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_feedback_unwrap_decoder_unit_tb
// Drives feedback frames through the decoder under several register settings
// and handshake idling patterns. Each accepted frame for the configured motor
// is unwrapped and scaled by an in-bench predictor, and every result
// transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module motor_feedback_unwrap_decoder_unit_tb;
    import mfud_pkg::*;

    localparam int ModeNone    = 0;
    localparam int ModeSrcIdle = 1;
    localparam int ModeSnkStal = 2;
    localparam int ModeBoth    = 3;

    localparam logic [CfgIdxW-1:0] RegUnused = CfgIdxW'(7);

    logic clk = 1'b0;
    logic rst_n;

    mfud_cfg_if    cfg_bus ();
    mfud_frame_if  frame_bus ();
    mfud_result_if result_bus ();

    motor_feedback_unwrap_decoder_unit u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_bus),
        .frame_in   (frame_bus),
        .result_out (result_bus)
    );

    // predictor state and register copy
    cfg_t                  motor_cfg;
    logic [FrameCntW-1:0]  rx_frames;
    logic [AngleW-1:0]     last_angle;
    logic [AngleW-1:0]     zero_angle;
    logic [TurnW-1:0]      turn_acc;

    frame_t  frames_to_send[$];
    result_t predicted_results[$];
    frame_t  on_bus;

    logic [AngleW-1:0] walk_angle = '0;
    int  src_idle_pct = 0;
    int  snk_stall_pct = 0;
    int  mismatches = 0;
    bit  pressure_start = 1'b0;
    logic hold_off;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // raw times Q8.24 gain, floor shift to Q16.16, saturate to w bits
    function automatic logic [PosW-1:0] sat_scale(input logic signed [TotalW:0] v,
                                                  input logic [GainW-1:0] g,
                                                  input int w);
        logic signed [TotalW+GainW+1:0] prod;
        logic signed [TotalW+GainW+1:0] lim;
        prod = (TotalW+GainW+2)'(v) * (TotalW+GainW+2)'($signed({1'b0, g}));
        prod = prod >>> QShift;
        lim  = 1;
        lim  = lim <<< (w - 1);
        if (prod >= lim)
            prod = lim - 1;
        else if (prod < -lim)
            prod = -lim;
        return prod[PosW-1:0];
    endfunction

    function automatic bit unwrap_frame(input frame_t f, output result_t r);
        logic signed [AngleW:0] jump;
        logic [TotalW-1:0]      total;
        r = '0;
        if (f.bus_channel >= NumChannels || f.bus_channel != motor_cfg.motor_channel ||
            f.frame_id != motor_cfg.motor_id)
            return 1'b0;
        if (rx_frames != '1)
            rx_frames++;
        jump = $signed({1'b0, f.angle_raw}) - $signed({1'b0, last_angle});
        last_angle = f.angle_raw;
        r.in_warmup = rx_frames < motor_cfg.warmup_frames;
        if (r.in_warmup)
        begin
            zero_angle = f.angle_raw;
            turn_acc   = '0;
        end
        if (jump >= JumpLimit)
            turn_acc--;
        else if (jump <= -JumpLimit)
            turn_acc++;
        total = (TotalW'($signed(turn_acc)) << RevShift) + TotalW'(f.angle_raw)
                - TotalW'(zero_angle);
        r.total_count  = total;
        r.turn_count   = turn_acc;
        r.position_q16 = sat_scale((TotalW+1)'($signed(total)), motor_cfg.position_gain, PosW);
        r.velocity_q16 = FixW'(sat_scale((TotalW+1)'(f.speed_raw),
                                         motor_cfg.velocity_gain, FixW));
        r.torque_q16   = FixW'(sat_scale((TotalW+1)'(f.current_raw),
                                         motor_cfg.torque_gain, FixW));
        r.temperature  = f.temperature_raw;
        return 1'b1;
    endfunction

    function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                      input logic [CfgDataW-1:0] value);
        case (idx)
            RegMotorId:      motor_cfg.motor_id      = IdW'(value);
            RegMotorChannel: motor_cfg.motor_channel = ChanW'(value);
            RegWarmupFrames: motor_cfg.warmup_frames = FrameCntW'(value);
            RegPositionGain: motor_cfg.position_gain = value;
            RegVelocityGain: motor_cfg.velocity_gain = value;
            RegTorqueGain:   motor_cfg.torque_gain   = value;
            default: ;
        endcase
    endfunction

    function automatic frame_t mk_frame(input logic [ChanW-1:0] ch, input logic [IdW-1:0] id,
                                        input logic [AngleW-1:0] angle,
                                        input logic [RawW-1:0] speed,
                                        input logic [RawW-1:0] current,
                                        input logic [TempW-1:0] temp);
        frame_t f;
        f.bus_channel     = ch;
        f.frame_id        = id;
        f.angle_raw       = angle;
        f.speed_raw       = speed;
        f.current_raw     = current;
        f.temperature_raw = temp;
        return f;
    endfunction

    // angle follows a random walk with occasional wild and boundary jumps
    function automatic frame_t random_frame(input bit for_motor);
        frame_t f;
        case ($urandom_range(9))
            0: walk_angle = AngleW'($urandom);
            1:
            begin
                case ($urandom_range(3))
                    0: walk_angle = walk_angle + AngleW'(4095);
                    1: walk_angle = walk_angle + AngleW'(4096);
                    2: walk_angle = walk_angle - AngleW'(4095);
                    default: walk_angle = walk_angle - AngleW'(4096);
                endcase
            end
            default: walk_angle = walk_angle + AngleW'($urandom_range(10000) - 5000);
        endcase
        f.bus_channel     = for_motor ? motor_cfg.motor_channel : ChanW'($urandom);
        f.frame_id        = for_motor ? motor_cfg.motor_id : IdW'($urandom);
        f.angle_raw       = walk_angle;
        f.speed_raw       = RawW'($urandom);
        f.current_raw     = RawW'($urandom);
        f.temperature_raw = TempW'($urandom);
        return f;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        result_t want;
        if (predicted_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t unexpected result transaction", $time);
            return;
        end
        want = predicted_results.pop_front();
        compare_field("total_count", 64'(want.total_count), 64'(result_bus.total_count));
        compare_field("turn_count", 64'(want.turn_count), 64'(result_bus.turn_count));
        compare_field("position_q16", 64'(want.position_q16),
                      64'(result_bus.position_q16));
        compare_field("velocity_q16", 64'(want.velocity_q16),
                      64'(result_bus.velocity_q16));
        compare_field("torque_q16", 64'(want.torque_q16), 64'(result_bus.torque_q16));
        compare_field("temperature", 64'(want.temperature), 64'(result_bus.temperature));
        compare_field("in_warmup", 64'(want.in_warmup), 64'(result_bus.in_warmup));
    endtask

    // frame driver
    always @(posedge clk)
    begin
        result_t pred;
        frame_t  nxt;
        if (rst_n)
        begin
            if (frame_bus.valid && frame_bus.ready)
            begin
                if (unwrap_frame(on_bus, pred))
                    predicted_results.push_back(pred);
            end
            if (!frame_bus.valid || frame_bus.ready)
            begin
                if (frames_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nxt = frames_to_send.pop_front();
                    on_bus                    <= nxt;
                    frame_bus.valid           <= 1'b1;
                    frame_bus.bus_channel     <= nxt.bus_channel;
                    frame_bus.frame_id        <= nxt.frame_id;
                    frame_bus.angle_raw       <= nxt.angle_raw;
                    frame_bus.speed_raw       <= nxt.speed_raw;
                    frame_bus.current_raw     <= nxt.current_raw;
                    frame_bus.temperature_raw <= nxt.temperature_raw;
                end
                else
                    frame_bus.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
                check_result();
            result_bus.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // long receiver hold-off so the pipeline backs up into the input
    initial
    begin
        hold_off = 1'b0;
        wait (pressure_start);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        apply_reg(idx, value);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_mode(input int mode);
        case (mode)
            ModeSrcIdle: begin src_idle_pct <= 68; snk_stall_pct <= 0;  end
            ModeSnkStal: begin src_idle_pct <= 0;  snk_stall_pct <= 68; end
            ModeBoth:    begin src_idle_pct <= 35; snk_stall_pct <= 35; end
            default:     begin src_idle_pct <= 0;  snk_stall_pct <= 0;  end
        endcase
    endtask

    // wait for all transactions to complete, then let dropped frames clear
    task automatic settle();
        int waited;
        waited = 0;
        do
        begin
            @(posedge clk);
            if (frames_to_send.size() == 0 && !frame_bus.valid)
                waited++;
        end
        while ((frames_to_send.size() != 0 || frame_bus.valid ||
                predicted_results.size() != 0) && waited < 2000);
        repeat (8) @(posedge clk);
    endtask

    task automatic randomize_regs();
        logic [CfgDataW-1:0] gain;
        write_reg(RegMotorId, CfgDataW'($urandom_range(2047)));
        write_reg(RegMotorChannel, CfgDataW'($urandom_range(1)));
        case ($urandom_range(3))
            0: write_reg(RegWarmupFrames, '0);
            1: write_reg(RegWarmupFrames, CfgDataW'(1));
            2: write_reg(RegWarmupFrames, CfgDataW'(rx_frames) + $urandom_range(2, 60));
            default: write_reg(RegWarmupFrames, CfgDataW'($urandom_range(65535)));
        endcase
        for (int r = RegPositionGain; r <= RegTorqueGain; r++)
        begin
            case ($urandom_range(4))
                0: gain = '0;
                1: gain = '1;
                default: gain = $urandom;
            endcase
            write_reg(CfgIdxW'(r), gain);
        end
    endtask

    task automatic queue_random(input int hits_wanted, input int noise_pct);
        int hits;
        frame_t f;
        hits = 0;
        while (hits < hits_wanted)
        begin
            f = random_frame($urandom_range(99) >= noise_pct);
            if (f.bus_channel == motor_cfg.motor_channel && f.frame_id == motor_cfg.motor_id)
                hits++;
            frames_to_send.push_back(f);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data  = '0;
        frame_bus.valid           = 1'b0;
        frame_bus.bus_channel     = '0;
        frame_bus.frame_id        = '0;
        frame_bus.angle_raw       = '0;
        frame_bus.speed_raw       = '0;
        frame_bus.current_raw     = '0;
        frame_bus.temperature_raw = '0;
        result_bus.ready = 1'b0;
        on_bus = '0;
        motor_cfg = '{MotorIdRst, MotorChannelRst, WarmupFramesRst,
                      PositionGainRst, VelocityGainRst, TorqueGainRst};
        rx_frames  = '0;
        last_angle = '0;
        zero_angle = '0;
        turn_acc   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: first frame compared against zero, jumps during warmup
        set_mode(ModeNone);
        frames_to_send.push_back(mk_frame(1'b1, 11'd513, 16'h1234, 16'h0001, 16'h0001, 8'h01));
        frames_to_send.push_back(mk_frame(1'b0, 11'd512, 16'h1234, 16'h0001, 16'h0001, 8'h01));
        frames_to_send.push_back(mk_frame(1'b0, 11'd513, 16'h7000, 16'h7FFF, 16'h8000, 8'hFF));
        frames_to_send.push_back(mk_frame(1'b0, 11'd513, 16'h0100, 16'h8000, 16'h7FFF, 8'h00));
        frames_to_send.push_back(mk_frame(1'b0, 11'd513, 16'hFFFF, 16'h0000, 16'hFFFF, 8'h5A));
        settle();

        // no warmup, full-scale gains, jump thresholds
        write_reg(RegMotorId, CfgDataW'(2047));
        write_reg(RegMotorChannel, CfgDataW'(1));
        write_reg(RegWarmupFrames, CfgDataW'(1));
        write_reg(RegPositionGain, '1);
        write_reg(RegVelocityGain, '1);
        write_reg(RegTorqueGain, '1);
        write_reg(RegUnused, '1);
        frames_to_send.push_back(mk_frame(1'b1, 11'd2047, 16'h0000, 16'h7FFF, 16'h7FFF, 8'hFF));
        frames_to_send.push_back(mk_frame(1'b1, 11'd2047, 16'h1000, 16'h8000, 16'h8000, 8'h00));
        frames_to_send.push_back(mk_frame(1'b1, 11'd2047, 16'h0001, 16'hFFFF, 16'h0001, 8'h80));
        frames_to_send.push_back(mk_frame(1'b1, 11'd2047, 16'h1000, 16'h0001, 16'hFFFF, 8'h7F));
        frames_to_send.push_back(mk_frame(1'b1, 11'd2047, 16'h0000, 16'h0000, 16'h0000, 8'hAA));
        frames_to_send.push_back(mk_frame(1'b0, 11'd2047, 16'h5555, 16'h5555, 16'h5555, 8'h55));
        frames_to_send.push_back(mk_frame(1'b1, 11'd0, 16'hAAAA, 16'hAAAA, 16'hAAAA, 8'hAA));
        frames_to_send.push_back(mk_frame(1'b1, 11'd2046, 16'h5555, 16'h5555, 16'h5555, 8'h55));
        settle();

        // zero gains, warmup held open, half-turn swings
        write_reg(RegMotorId, '0);
        write_reg(RegMotorChannel, '0);
        write_reg(RegWarmupFrames, CfgDataW'(65535));
        write_reg(RegPositionGain, '0);
        write_reg(RegVelocityGain, '0);
        write_reg(RegTorqueGain, '0);
        frames_to_send.push_back(mk_frame(1'b0, 11'd0, 16'h8000, 16'h7FFF, 16'h8000, 8'hFF));
        frames_to_send.push_back(mk_frame(1'b0, 11'd0, 16'h0000, 16'h8000, 16'h7FFF, 8'h00));
        frames_to_send.push_back(mk_frame(1'b0, 11'd0, 16'hFFFF, 16'h1234, 16'hEDCB, 8'h3C));
        settle();

        for (int ph = 0; ph < 8; ph++)
        begin
            set_mode(ph % 4);
            randomize_regs();
            queue_random(85, 25);
            settle();
        end

        set_mode(ModeNone);
        randomize_regs();
        pressure_start = 1'b1;
        queue_random(60, 10);
        settle();

        set_mode(ModeBoth);
        randomize_regs();
        write_reg(RegWarmupFrames, CfgDataW'(65535));
        queue_random(80, 25);
        settle();

        repeat (20) @(posedge clk);
        if (predicted_results.size() != 0)
        begin
            mismatches += predicted_results.size();
            $display("%0t %0d predicted results never arrived", $time,
                     predicted_results.size());
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
